// ===== hw/rtl/annexb_pkg.sv =====
// ============================================================================
// annexb_pkg
// Shared types and constants for the Annex B start code splitter.
// ============================================================================
package annexb_pkg;

    // start code bytes
    localparam logic [7:0] START_ZERO = 8'h00;
    localparam logic [7:0] START_ONE  = 8'h01;

    // delay window, results per input word, output queue
    localparam int WIN_DEPTH = 4;
    localparam int MAX_RES   = 5;
    localparam int Q_DEPTH   = 8;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int RES_W     = $clog2(MAX_RES + 1);
    localparam int CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int Q_IDX_W   = $clog2(Q_DEPTH);
    localparam int RES_IDX_W = $clog2(MAX_RES);

    // queue accepts a new input word only while this many entries or fewer wait
    localparam int ACCEPT_MAX = Q_DEPTH - MAX_RES;

    // one output word
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_res;

endpackage

// ===== hw/rtl/annexb_nal_unit_splitter.sv =====
// ============================================================================
// annexb_nal_unit_splitter
// Splits an Annex B byte stream into units at 00 00 01 start codes.
// ============================================================================
// A byte stream enters one byte per word on the slave side and unit payload
// bytes leave on the master side, start codes removed, each marked with first
// (tuser) and last (tlast). A zero ahead of 00 00 01 belongs to the start code.
// Bytes before the first start code are dropped; tlast on the input ends the
// stream, flushes the open unit and returns the block to its reset state.
// One input byte is taken per clock while s_axis_tready is high: a byte is
// decoded combinationally against a four-byte delay window and its zero to
// five output words go into an eight-entry output queue. Input is accepted
// while three or fewer words wait in that queue, so with the master side
// always ready the block runs at one byte per cycle; only the flush burst at
// end of stream can hold the input. A word written into an empty queue is
// offered on the master side in the cycle right after the edge that writes it.
module annexb_nal_unit_splitter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] stream_byte
    input  logic                  s_axis_tlast,   // stream_end
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] unit_byte
    output logic [0:0]            m_axis_tuser,   // [0] unit_first
    output logic                  m_axis_tlast    // unit_last
);
    import annexb_pkg::*;

    // window, newest byte at the top index
    logic [7:0]        r_win [WIN_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic              r_inside;
    logic              r_first;
    t_res              r_q [Q_DEPTH];
    logic [CNT_W-1:0]  r_cnt;

    logic [7:0]        n_win [WIN_DEPTH];
    logic [FILL_W-1:0] n_fill;
    logic              n_inside;
    logic              n_first;
    t_res              n_q [Q_DEPTH];
    logic [CNT_W-1:0]  n_cnt;

    logic              push;
    logic              pop;
    logic              code3;
    logic              code4;
    logic              overflow;
    logic              last_en;
    logic [FILL_W-1:0] n_bytes;
    logic [FILL_W-1:0] pay;
    logic [RES_W-1:0]  k;
    logic [RES_W-1:0]  last_idx;
    logic [2:0]        sh;
    logic [8*MAX_RES-1:0] vec;
    logic [8*MAX_RES-1:0] ord;
    t_res              w_res [MAX_RES];
    logic [CNT_W-1:0]  base;
    logic [CNT_W-1:0]  off;

    // handshakes
    assign s_axis_tready = (r_cnt <= CNT_W'(ACCEPT_MAX));
    assign m_axis_tvalid = (r_cnt != '0);
    assign push          = s_axis_tvalid & s_axis_tready;
    assign pop           = m_axis_tvalid & m_axis_tready;

    // queue head drives the output
    assign m_axis_tdata    = r_q[0].data;
    assign m_axis_tuser[0] = r_q[0].first;
    assign m_axis_tlast    = r_q[0].last;

    // start code detection on the newest bytes
    assign code3 = (r_fill >= FILL_W'(2)) && (r_win[WIN_DEPTH-2] == START_ZERO)
                 && (r_win[WIN_DEPTH-1] == START_ZERO) && (s_axis_tdata == START_ONE);
    assign code4 = code3 && (r_fill >= FILL_W'(3)) && (r_win[WIN_DEPTH-3] == START_ZERO);
    assign overflow = (r_fill == FILL_W'(WIN_DEPTH));

    // known bytes, oldest first
    assign n_bytes = r_fill + FILL_W'(1);
    assign sh      = 3'(WIN_DEPTH) - 3'(r_fill);
    assign vec     = {s_axis_tdata, r_win[3], r_win[2], r_win[1], r_win[0]};
    assign ord     = vec >> {sh, 3'b000};
    assign pay     = n_bytes - (code4 ? FILL_W'(4) : FILL_W'(3));

    // number of words produced by this byte
    always_comb begin
        if (code3) begin
            k = r_inside ? RES_W'(pay) : '0;
        end else if (s_axis_tlast) begin
            k = r_inside ? RES_W'(n_bytes) : '0;
        end else if (overflow && r_inside) begin
            k = RES_W'(1);
        end else begin
            k = '0;
        end
    end

    assign last_en  = code3 | s_axis_tlast;
    assign last_idx = k - RES_W'(1);

    // result words
    always_comb begin
        for (int j = 0; j < MAX_RES; j++) begin
            w_res[j].data  = ord[8*j +: 8];
            w_res[j].first = (j == 0) && r_first;
            w_res[j].last  = last_en && (RES_W'(j) == last_idx);
        end
    end

    // window and unit state update
    always_comb begin
        n_win    = r_win;
        n_fill   = r_fill;
        n_inside = r_inside;
        n_first  = r_first;
        if (push) begin
            if (code3) begin
                n_fill   = '0;
                n_inside = !s_axis_tlast;
                n_first  = !s_axis_tlast;
            end else if (s_axis_tlast) begin
                n_fill   = '0;
                n_inside = 1'b0;
                n_first  = 1'b0;
            end else begin
                for (int j = 0; j < WIN_DEPTH - 1; j++) begin
                    n_win[j] = r_win[j+1];
                end
                n_win[WIN_DEPTH-1] = s_axis_tdata;
                n_fill = overflow ? r_fill : n_bytes;
                if (k != '0) begin
                    n_first = 1'b0;
                end
            end
        end
    end

    // output queue: shift on pop, append results behind the remaining words
    assign base = r_cnt - CNT_W'(pop);
    always_comb begin
        off = '0;
        for (int j = 0; j < Q_DEPTH; j++) begin
            if (pop && j < Q_DEPTH - 1) begin
                n_q[j] = r_q[(j + 1) % Q_DEPTH];
            end else begin
                n_q[j] = r_q[j];
            end
            off = CNT_W'(j) - base;
            if (push && (CNT_W'(j) >= base) && (off < CNT_W'(k))) begin
                n_q[j] = w_res[off[RES_IDX_W-1:0]];
            end
        end
        n_cnt = base + (push ? CNT_W'(k) : '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_inside <= 1'b0;
            r_first  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_fill   <= n_fill;
            r_inside <= n_inside;
            r_first  <= n_first;
            r_cnt    <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_q   <= n_q;
    end

    // queue never overfills
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(Q_DEPTH))
        else $error("output queue count out of range");

    // window fill stays within the window
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WIN_DEPTH))
        else $error("window fill out of range");

    // end of stream returns to the reset state
    a_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && s_axis_tlast) |=> (!r_inside && !r_first && r_fill == '0))
        else $error("stream end did not clear unit state");

    // a word taken with nothing new leaves the count one lower
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("queue count mismatch after pop");

    // bytes outside a unit never produce words
    a_outside_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !r_inside && !pop) |=> (r_cnt == $past(r_cnt)))
        else $error("word produced outside a unit");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the Annex B start code splitter.
// ============================================================================
// Byte streams are queued up front: a short directed stream that hits
// leading garbage, three- and four-byte start codes, an empty unit, window
// overflow and every way a stream can end. Random streams of start codes and
// zero-heavy payload follow, with some noise streams mixed in. The sender
// goes in bursts with random gaps and the receiver stalls on a changing
// pattern. Each accepted byte runs through a behavioral splitter that queues
// the unit words it should cause. Each output word is then checked in order
// against the oldest queued word.
module tb;
    import annexb_pkg::*;

    localparam int NUM_ITEMS   = 280;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_TICKS = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_stream_word;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] stream_byte
    logic       s_axis_tlast  = 1'b0;    // stream_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] unit_byte
    logic [0:0] m_axis_tuser;            // [0] unit_first
    logic       m_axis_tlast;            // unit_last

    // stimulus and expected unit words
    t_stream_word pend_words[$];
    t_res         unit_words_due[$];

    // splitter model state
    logic [7:0] win [WIN_DEPTH];
    int         win_fill      = 0;
    logic       in_unit       = 1'b0;
    logic       open_pending  = 1'b0;

    // bookkeeping
    logic       in_taken      = 1'b0;
    int         errors        = 0;
    int         bytes_in      = 0;
    int         streams_in    = 0;
    int         words_out     = 0;
    int         units_out     = 0;
    int         idle_cycles   = 0;
    int         gap_left      = 0;
    int         burst_left    = 1;
    int         pat_ticks     = 0;
    logic [7:0] ready_pat     = 8'hFF;

    annexb_nal_unit_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // queue one expected unit word, first mark taken from the open flag
    function automatic void emit_unit_word(input logic [7:0] b, input logic last);
        t_res w;
        w.data  = b;
        w.first = open_pending;
        w.last  = last;
        unit_words_due.push_back(w);
        open_pending = 1'b0;
    endfunction

    // back to the state after reset: a new stream begins
    function automatic void restart_stream();
        win_fill     = 0;
        in_unit      = 1'b0;
        open_pending = 1'b0;
    endfunction

    // run one accepted byte through the splitter model
    function automatic void split_byte(input logic [7:0] b, input logic eos);
        logic [7:0] t [WIN_DEPTH + 1];
        int n;
        int code_len;
        int pay;
        int keep;
        int i;
        for (i = 0; i < win_fill; i++)
            t[i] = win[i];
        t[win_fill] = b;
        n = win_fill + 1;
        code_len = 0;

        // start code ending on the newest byte, with an optional leading zero
        if (n >= 3 && t[n-3] == START_ZERO && t[n-2] == START_ZERO && t[n-1] == START_ONE) begin
            code_len = 3;
            if (n >= 4 && t[n-4] == START_ZERO)
                code_len = 4;
        end

        if (code_len != 0) begin
            if (in_unit) begin
                pay = n - code_len;
                for (i = 0; i < pay; i++)
                    emit_unit_word(t[i], i == pay - 1);
            end
            if (eos) begin
                restart_stream();
            end else begin
                in_unit      = 1'b1;
                open_pending = 1'b1;
                win_fill     = 0;
            end
            return;
        end

        // end of stream flushes the open unit
        if (eos) begin
            if (in_unit) begin
                for (i = 0; i < n; i++)
                    emit_unit_word(t[i], i == n - 1);
            end
            restart_stream();
            return;
        end

        // window overflow: oldest byte leaves or is dropped
        keep = 0;
        if (n > WIN_DEPTH) begin
            if (in_unit)
                emit_unit_word(t[0], 1'b0);
            keep = 1;
        end
        for (i = keep; i < n; i++)
            win[i - keep] = t[i];
        win_fill = n - keep;
    endfunction

    function automatic void queue_word(input logic [7:0] b, input logic eos);
        t_stream_word w;
        w.data = b;
        w.eos  = eos;
        pend_words.push_back(w);
    endfunction

    // payload byte biased toward zeros and ones so codes form by chance too
    function automatic logic [7:0] pick_payload_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0, 1:    b = START_ZERO;
            2:       b = START_ONE;
            3:       b = 8'h03;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    // one random stream: mostly well-formed units, sometimes plain noise
    function automatic void queue_random_stream();
        int kind;
        int units;
        int len;
        int u;
        int i;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
                queue_word(pick_payload_byte(), 1'b0);
        end else begin
            if (kind == 1) begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    queue_word(8'($urandom), 1'b0);
            end
            units = $urandom_range(1, 4);
            for (u = 0; u < units; u++) begin
                if ($urandom_range(0, 1) == 1)
                    queue_word(START_ZERO, 1'b0);
                queue_word(START_ZERO, 1'b0);
                queue_word(START_ZERO, 1'b0);
                queue_word(START_ONE, 1'b0);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14)
                                                  : $urandom_range(0, 6);
                for (i = 0; i < len; i++)
                    queue_word(pick_payload_byte(), 1'b0);
            end
        end
        // most streams end here, a few run on into the next one
        if (kind != 9)
            pend_words[pend_words.size() - 1].eos = 1'b1;
    endfunction

    // stream source: bursts of words with random gaps
    always @(negedge i_clk) begin
        t_stream_word nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !in_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 8'($urandom);
                s_axis_tlast  <= 1'($urandom);
            end else if (pend_words.size() != 0) begin
                nxt = pend_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.data;
                s_axis_tlast  <= nxt.eos;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end

        // unit sink: stall on a rotating pattern that changes now and then
        m_axis_tready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[7:1]};
        pat_ticks++;
        if (pat_ticks >= 50) begin
            pat_ticks = 0;
            case ($urandom_range(0, 3))
                0:       ready_pat = 8'hFF;
                1:       ready_pat = 8'h01;
                default: ready_pat = 8'($urandom) | 8'h01;
            endcase
        end
    end

    // monitor: predict on accepted bytes, check every unit word, watchdog
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                split_byte(s_axis_tdata, s_axis_tlast);
                bytes_in++;
                if (s_axis_tlast)
                    streams_in++;
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got.data  = m_axis_tdata;
                got.first = m_axis_tuser[0];
                got.last  = m_axis_tlast;
                words_out++;
                if (got.last)
                    units_out++;
                if (unit_words_due.size() == 0) begin
                    $error("unexpected unit word: unit_byte %02h first %0b last %0b",
                           got.data, got.first, got.last);
                    errors++;
                end else begin
                    want = unit_words_due.pop_front();
                    if (got.data !== want.data) begin
                        $error("unit_byte: expected %02h, got %02h", want.data, got.data);
                        errors++;
                    end
                    if (got.first !== want.first) begin
                        $error("unit_first: expected %0b, got %0b", want.first, got.first);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("unit_last: expected %0b, got %0b", want.last, got.last);
                        errors++;
                    end
                end
            end

            // watchdog on cycles with no word moving on either side
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("annexb_nal_unit_splitter: mismatch");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        // garbage before the first code is dropped
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b0);
        // with the garbage zero these form a four-byte code that opens a unit
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ONE, 1'b0);
        queue_word(8'hAB, 1'b0);
        // four-byte code closes it, leading zero stays out of the unit
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ONE, 1'b0);
        // adjacent code gives an empty unit
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ONE, 1'b0);
        // window overflow, then end of stream inside a unit
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'h7F, 1'b0);
        queue_word(8'h80, 1'b0);
        queue_word(8'h3C, 1'b0);
        queue_word(START_ONE, 1'b1);
        // end of stream outside any unit
        queue_word(8'h55, 1'b1);
        // code ending on the final byte
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ZERO, 1'b0);
        queue_word(START_ONE, 1'b1);

        while (pend_words.size() < NUM_ITEMS)
            queue_random_stream();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all stimulus taken and all unit words seen, then drain
        while (pend_words.size() != 0 || s_axis_tvalid || unit_words_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);

        $display("covered %0d stream bytes closing %0d streams", bytes_in, streams_in);
        $display("checked %0d unit bytes closing %0d units", words_out, units_out);
        if (errors == 0)
            $display("annexb_nal_unit_splitter: match");
        else
            $display("annexb_nal_unit_splitter: mismatch");
        $finish;
    end

endmodule
